// ===== sv/fqd_pkg.sv =====
// shared types and codes for the fifo queue with delete
`default_nettype none
package fqd_pkg;

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_DEL = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_REJ  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CMP  = 2'd1,
        S_UPD  = 2'd2
    } t_state;

    typedef struct packed {
        logic cmp;
        logic shift;
        logic write;
    } t_cell_ctl;

    localparam int OccWidth  = 5;
    localparam int PortWidth = 32;

endpackage
`default_nettype wire

// ===== sv/fqd_cell.sv =====
// one queue entry cell: holds a value, matches it, and closes up from its neighbor
`default_nettype none
module fqd_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int CW          = 5,
    parameter int IDX         = 0
) (
    input  wire logic                   i_clk,
    input  wire fqd_pkg::t_cell_ctl     i_ctl,
    input  wire logic [CW-1:0]          i_cnt,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic [VALUE_WIDTH-1:0] i_next_data,
    input  wire logic                   i_kill,
    output logic                        o_kill,
    output logic [VALUE_WIDTH-1:0]      o_data
);
    import fqd_pkg::*;

    logic [VALUE_WIDTH-1:0] r_data;
    logic                   r_match;
    logic                   valid;

    assign valid  = CW'(IDX) < i_cnt;
    assign o_kill = i_kill | r_match;
    assign o_data = r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_match <= valid && (r_data == i_value);
        end
        if (i_ctl.shift && o_kill) begin
            r_data <= i_next_data;
        end else if (i_ctl.write && (i_cnt == CW'(IDX))) begin
            r_data <= i_value;
        end
    end

endmodule
`default_nettype wire

// ===== sv/fifo_queue_with_delete_top.sv =====
// fifo queue with delete: control sequencer over a row of entry cells
// each item goes through accept, parallel compare and shift/commit before the next is taken
// shift/commit registers the result, and waits in S_UPD while the output register is still full
// a new item is taken while a finished result waits in the output register
// reset (synchronous, active low) empties the queue and clears the output valid
// entry storage has no reset; only entries below the count are ever read
`default_nettype none
module fifo_queue_with_delete_top #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // op[1:0], value[33:2], zero fill
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata   // status[1:0], value_out[33:2], occupancy[38:34]
);
    import fqd_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (VALUE_WIDTH < PortWidth) ? VALUE_WIDTH : PortWidth;

    t_state                 r_state, n_state;
    t_op                    r_op;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_ovalid;
    logic [39:0]            r_odata;

    t_cell_ctl              ctl;
    t_status                status;
    logic                   commit;
    logic                   accept;
    logic                   found;
    logic [PortWidth-1:0]   vout;
    logic [CW+OccWidth-1:0] occ_ext;
    logic                   kill [DEPTH+1];
    logic [VALUE_WIDTH-1:0] cell_data [DEPTH];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign kill[0] = (r_op == OP_DEQ);
    assign found   = kill[DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        fqd_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .CW          (CW),
            .IDX         (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_cnt       (r_cnt),
            .i_value     (r_val),
            .i_next_data (cell_data[(g < DEPTH - 1) ? g + 1 : g]),
            .i_kill      (kill[g]),
            .o_kill      (kill[g+1]),
            .o_data      (cell_data[g])
        );
    end

    always_comb begin
        n_state   = r_state;
        ctl       = '0;
        commit    = 1'b0;
        status    = ST_REJ;
        n_cnt     = r_cnt;
        vout      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                ctl.cmp = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                if (!r_ovalid || m_axis_tready) begin
                    commit  = 1'b1;
                    n_state = S_IDLE;
                    unique case (r_op)
                        OP_ENQ: begin
                            if (r_val == '0) begin
                                status = ST_REJ;
                            end else if (r_cnt >= CW'(DEPTH)) begin
                                status = ST_FULL;
                            end else begin
                                status    = ST_OK;
                                ctl.write = 1'b1;
                                n_cnt     = r_cnt + 1'b1;
                            end
                        end
                        OP_DEQ: begin
                            if (r_cnt != '0) begin
                                status    = ST_OK;
                                ctl.shift = 1'b1;
                                n_cnt     = r_cnt - 1'b1;
                                vout      = PortWidth'(cell_data[0][IW-1:0]);
                            end
                        end
                        OP_DEL: begin
                            if ((r_val != '0) && found) begin
                                status    = ST_OK;
                                ctl.shift = 1'b1;
                                n_cnt     = r_cnt - 1'b1;
                            end
                        end
                        default: begin
                            status = ST_REJ;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        occ_ext = {{OccWidth{1'b0}}, n_cnt};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (commit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= t_op'(s_axis_tdata[1:0]);
            r_val <= VALUE_WIDTH'(s_axis_tdata[2 +: IW]);
        end
        if (commit) begin
            r_odata <= {1'b0, occ_ext[OccWidth-1:0], vout, status};
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit && (r_op == OP_ENQ) && (status == ST_OK) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("enqueue did not grow the count");

    a_vout_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && (r_odata[33:2] != '0) |-> r_odata[1:0] == ST_OK)
        else $error("value returned without success");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> !accept)
        else $error("input taken while an item is in work");
`endif

endmodule
`default_nettype wire
